// ----- hw/rtl/triangle_raster_supersample_interp_top_defines.svh -----
// ----------------------------------------------------------------------------
// triangle raster assertion macros
// shared property forms for the rasteriser checks
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_RASTER_SUPERSAMPLE_INTERP_TOP_DEFINES_SVH
`define TRIANGLE_RASTER_SUPERSAMPLE_INTERP_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk, quiet in reset
`define TRSI_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rasteriser check failed");

// next-cycle implication, clocked on clk, quiet in reset
`define TRSI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rasteriser check failed");

`endif

// ----- hw/rtl/trsi_pkg.sv -----
// ----------------------------------------------------------------------------
// trsi_pkg
// constants and codes shared by the rasteriser files
// ----------------------------------------------------------------------------
package trsi_pkg;

  // colour fields
  localparam int LEVEL_BITS = 7;
  localparam int COLOR_BITS = 3 * LEVEL_BITS;
  localparam int LEVEL_MAX  = 100;
  // quotient saturates once the rounded numerator reaches 2*(max+1)*t
  localparam int SAT_FACTOR = 2 * (LEVEL_MAX + 1);

  // configuration register indexes
  localparam int CFG_IDX_BITS = 3;
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_A_POS   = 3'd0,
    CFG_B_POS   = 3'd1,
    CFG_C_POS   = 3'd2,
    CFG_A_COLOR = 3'd3,
    CFG_B_COLOR = 3'd4,
    CFG_C_COLOR = 3'd5
  } cfg_index_t;

endpackage

// ----- hw/rtl/trsi_if.sv -----
// ----------------------------------------------------------------------------
// trsi interfaces
// pixel request channel and sample result channel
// ----------------------------------------------------------------------------
interface trsi_in_if #(
  parameter int COORD_BITS = 12
) ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_row;
  logic [COORD_BITS-1:0] pixel_col;

  modport source (output valid, output pixel_row, output pixel_col, input ready);
  modport sink   (input valid, input pixel_row, input pixel_col, output ready);
endinterface

interface trsi_out_if
  import trsi_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic                  pixel_covered;
  logic [1:0]            sample_index;
  logic                  sample_covered;
  logic [LEVEL_BITS-1:0] red_level;
  logic [LEVEL_BITS-1:0] green_level;
  logic [LEVEL_BITS-1:0] blue_level;
  logic                  last_sample;

  modport source (output valid, output pixel_covered, output sample_index,
                  output sample_covered, output red_level, output green_level,
                  output blue_level, output last_sample, input ready);
  modport sink   (input valid, input pixel_covered, input sample_index,
                  input sample_covered, input red_level, input green_level,
                  input blue_level, input last_sample, output ready);
endinterface

// ----- hw/rtl/triangle_raster_supersample_interp_top.sv -----
// ----------------------------------------------------------------------------
// triangle_raster_supersample_interp_top
// pixel coverage with 2x2 supersampling and barycentric colour per sample
// ----------------------------------------------------------------------------
//  channel   dir  contents
//  pix_in    in   pixel_row, pixel_col
//  res_out   out  pixel/sample coverage, sample index, rgb levels, last flag
//  cfg_*     in   vertex positions and colours, written while idle
//
//  each pixel yields four results, one per cycle while res_out is not stalled;
//  the single result port sets that rate
//  a sample passes from issue through the overlap, product, numerator and divider stages to the output register
//  reset clears valid bits, the sample issue counter and the vertex registers
//  a stall on res_out freezes the whole pipeline; nothing is dropped
`include "triangle_raster_supersample_interp_top_defines.svh"

module triangle_raster_supersample_interp_top
  import trsi_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                                                clk,
  input  logic                                                rst,
  trsi_in_if.sink                                             pix_in,
  trsi_out_if.source                                          res_out,
  input  logic                                                cfg_we,
  input  logic [CFG_IDX_BITS-1:0]                             cfg_index,
  input  logic [((2*COORD_BITS > COLOR_BITS) ? 2*COORD_BITS : COLOR_BITS)-1:0] cfg_data
);

  localparam int GW = COORD_BITS + 2;
  localparam int AW = 2 * COORD_BITS + 5;
  localparam int WP = AW + LEVEL_BITS;
  localparam int WN = AW + LEVEL_BITS + 2;
  localparam int RW = AW + LEVEL_BITS + 4;
  localparam int ND = LEVEL_BITS + 1;

  typedef struct packed {
    logic       v;
    logic [1:0] s;
    logic       pix;
    logic       cov;
    logic       tz;
  } meta_t;

  // configuration registers
  logic [2*COORD_BITS-1:0] pos [3];
  logic [COLOR_BITS-1:0]   col [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        pos[i] <= '0;
        col[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_A_POS:   pos[0] <= cfg_data[2*COORD_BITS-1:0];
        CFG_B_POS:   pos[1] <= cfg_data[2*COORD_BITS-1:0];
        CFG_C_POS:   pos[2] <= cfg_data[2*COORD_BITS-1:0];
        CFG_A_COLOR: col[0] <= cfg_data[COLOR_BITS-1:0];
        CFG_B_COLOR: col[1] <= cfg_data[COLOR_BITS-1:0];
        CFG_C_COLOR: col[2] <= cfg_data[COLOR_BITS-1:0];
        default: ;
      endcase
    end
  end

  // doubled vertices
  logic [GW-1:0] vx [3];
  logic [GW-1:0] vy [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vx[i] = {1'b0, pos[i][COORD_BITS-1:0], 1'b0};
      vy[i] = {1'b0, pos[i][2*COORD_BITS-1:COORD_BITS], 1'b0};
    end
  end

  // pipeline advance: move unless the output register holds an untaken result
  logic ov;
  logic en;
  assign en = !ov || res_out.ready;

  // held pixel and sample issue counter
  logic                  held_valid;
  logic [1:0]            cnt;
  logic [COORD_BITS-1:0] row;
  logic [COORD_BITS-1:0] colm;
  logic                  acc;

  assign pix_in.ready = !held_valid || (en && cnt == 2'd3);
  assign acc = pix_in.valid && pix_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      cnt        <= '0;
    end else begin
      if (en && held_valid) begin
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) held_valid <= 1'b0;
      end
      if (acc) begin
        held_valid <= 1'b1;
        cnt        <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      row  <= pix_in.pixel_row;
      colm <= pix_in.pixel_col;
    end
  end

  // pixel and sample square origins
  logic [GW-1:0] px0, py0, sx0, sy0;
  assign px0 = {1'b0, colm, 1'b0};
  assign py0 = {1'b0, row, 1'b0};
  assign sx0 = {1'b0, colm, cnt[0]};
  assign sy0 = {1'b0, row, cnt[1]};

  logic          pix_hit, smp_hit;
  logic [AW-1:0] wa, wb, wc, tarea;
  logic [AW-1:0] pwa, pwb, pwc, ptarea;

  trsi_overlap #(.COORD_BITS(COORD_BITS)) u_pix (
    .clk(clk), .en(en), .vx(vx), .vy(vy), .x0(px0), .y0(py0), .size(2'd2),
    .hit(pix_hit), .wa(pwa), .wb(pwb), .wc(pwc), .tarea(ptarea)
  );

  trsi_overlap #(.COORD_BITS(COORD_BITS)) u_smp (
    .clk(clk), .en(en), .vx(vx), .vy(vy), .x0(sx0), .y0(sy0), .size(2'd1),
    .hit(smp_hit), .wa(wa), .wb(wb), .wc(wc), .tarea(tarea)
  );

  // meta for stages 1 to 3
  meta_t m1, m2, m3;
  always_ff @(posedge clk) begin
    if (rst) begin
      m1.v <= 1'b0;
      m2.v <= 1'b0;
      m3.v <= 1'b0;
    end else if (en) begin
      m1.v <= held_valid;
      m2.v <= m1.v;
      m3.v <= m2.v;
    end
    if (en) begin
      m1.s <= cnt;   m1.pix <= 1'b0; m1.cov <= 1'b0; m1.tz <= 1'b0;
      m2.s <= m1.s;  m2.pix <= 1'b0; m2.cov <= 1'b0; m2.tz <= 1'b0;
      m3.s <= m2.s;  m3.pix <= 1'b0; m3.cov <= 1'b0; m3.tz <= 1'b0;
    end
  end

  // stage 3: weight times colour products
  logic [WP-1:0] prod [3][3];
  logic [AW-1:0] t3;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int ch = 0; ch < 3; ch++) begin
        prod[ch][0] <= WP'(wa) * WP'(col[0][LEVEL_BITS*ch +: LEVEL_BITS]);
        prod[ch][1] <= WP'(wb) * WP'(col[1][LEVEL_BITS*ch +: LEVEL_BITS]);
        prod[ch][2] <= WP'(wc) * WP'(col[2][LEVEL_BITS*ch +: LEVEL_BITS]);
      end
      t3 <= tarea;
    end
  end

  // stage 4: rounded numerator, divisor and saturation bound
  logic [RW-1:0] rem4 [3];
  logic [RW-1:0] d4;
  logic [RW-1:0] lim4;
  meta_t         m4;
  always_ff @(posedge clk) begin
    logic [WN-1:0] num;
    if (rst) begin
      m4.v <= 1'b0;
    end else if (en) begin
      m4.v <= m3.v;
    end
    if (en) begin
      for (int ch = 0; ch < 3; ch++) begin
        num = WN'(prod[ch][0]) + WN'(prod[ch][1]) + WN'(prod[ch][2]);
        rem4[ch] <= (RW'(num) << 1) + RW'(t3);
      end
      d4      <= RW'(t3) << 1;
      lim4    <= RW'(t3) * RW'(SAT_FACTOR);
      m4.s    <= m3.s;
      m4.pix  <= pix_hit;
      m4.cov  <= pix_hit && smp_hit;
      m4.tz   <= (t3 == '0);
    end
  end

  // stages 5 to 12: saturation check, then one quotient bit per stage
  logic [RW-1:0]         drem [ND][3];
  logic [LEVEL_BITS-1:0] dq   [ND][3];
  logic                  dsat [ND][3];
  logic [RW-1:0]         dd   [ND];
  meta_t                 dm   [ND];

  always_ff @(posedge clk) begin
    logic [RW-1:0] sh;
    if (rst) begin
      for (int j = 0; j < ND; j++) dm[j].v <= 1'b0;
    end else if (en) begin
      dm[0].v <= m4.v;
      for (int j = 1; j < ND; j++) dm[j].v <= dm[j-1].v;
    end
    if (en) begin
      for (int ch = 0; ch < 3; ch++) begin
        drem[0][ch] <= rem4[ch];
        dq[0][ch]   <= '0;
        dsat[0][ch] <= (rem4[ch] >= lim4);
      end
      dd[0]     <= d4;
      dm[0].s   <= m4.s;
      dm[0].pix <= m4.pix;
      dm[0].cov <= m4.cov;
      dm[0].tz  <= m4.tz;
      for (int j = 1; j < ND; j++) begin
        for (int ch = 0; ch < 3; ch++) begin
          sh = dd[j-1] << (ND - 1 - j);
          if (drem[j-1][ch] >= sh) begin
            drem[j][ch] <= drem[j-1][ch] - sh;
            dq[j][ch]   <= dq[j-1][ch] | (LEVEL_BITS'(1) << (ND - 1 - j));
          end else begin
            drem[j][ch] <= drem[j-1][ch];
            dq[j][ch]   <= dq[j-1][ch];
          end
          dsat[j][ch] <= dsat[j-1][ch];
        end
        dd[j]     <= dd[j-1];
        dm[j].s   <= dm[j-1].s;
        dm[j].pix <= dm[j-1].pix;
        dm[j].cov <= dm[j-1].cov;
        dm[j].tz  <= dm[j-1].tz;
      end
    end
  end

  // output register
  logic [LEVEL_BITS-1:0] lvl [3];
  logic                  o_pix, o_cov, o_last;
  logic [1:0]            o_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (en) begin
      ov <= dm[ND-1].v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int ch = 0; ch < 3; ch++) begin
        if (!dm[ND-1].cov || dm[ND-1].tz) begin
          lvl[ch] <= '0;
        end else if (dsat[ND-1][ch]) begin
          lvl[ch] <= LEVEL_BITS'(LEVEL_MAX);
        end else begin
          lvl[ch] <= dq[ND-1][ch];
        end
      end
      o_pix  <= dm[ND-1].pix;
      o_cov  <= dm[ND-1].cov;
      o_s    <= dm[ND-1].s;
      o_last <= (dm[ND-1].s == 2'd3);
    end
  end

  assign res_out.valid          = ov;
  assign res_out.pixel_covered  = o_pix;
  assign res_out.sample_index   = o_s;
  assign res_out.sample_covered = o_cov;
  assign res_out.red_level      = lvl[0];
  assign res_out.green_level    = lvl[1];
  assign res_out.blue_level     = lvl[2];
  assign res_out.last_sample    = o_last;

  // checks
  `TRSI_ASSERT_NOW(a_last_on_fourth, res_out.valid, res_out.last_sample == (res_out.sample_index == 2'd3))
  `TRSI_ASSERT_NOW(a_sample_in_pixel, res_out.valid && res_out.sample_covered, res_out.pixel_covered)
  `TRSI_ASSERT_NOW(a_dark_when_open, res_out.valid && !res_out.sample_covered, (res_out.red_level == '0) && (res_out.green_level == '0) && (res_out.blue_level == '0))
  `TRSI_ASSERT_NEXT(a_transfer_held, pix_in.valid && pix_in.ready, held_valid && cnt == 2'd0)

endmodule

// ----- hw/rtl/trsi_overlap.sv -----
// ----------------------------------------------------------------------------
// trsi_overlap
// three-stage square against triangle overlap test on the half-pixel grid
// ----------------------------------------------------------------------------
module trsi_overlap
  import trsi_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [COORD_BITS+1:0]     vx [3],
  input  logic [COORD_BITS+1:0]     vy [3],
  input  logic [COORD_BITS+1:0]     x0,
  input  logic [COORD_BITS+1:0]     y0,
  input  logic [1:0]                size,
  output logic                      hit,
  output logic [2*COORD_BITS+4:0]   wa,
  output logic [2*COORD_BITS+4:0]   wb,
  output logic [2*COORD_BITS+4:0]   wc,
  output logic [2*COORD_BITS+4:0]   tarea
);

  localparam int GW = COORD_BITS + 2;
  localparam int PW = 2 * COORD_BITS + 6;
  localparam int AW = 2 * COORD_BITS + 5;
  localparam int NA = 13;
  localparam int NO = 24;

  function automatic logic signed [PW-1:0] dm(logic [GW-1:0] a, logic [GW-1:0] b,
                                              logic [GW-1:0] c, logic [GW-1:0] d);
    logic signed [GW:0] da;
    logic signed [GW:0] dc;
    da = $signed({1'b0, a}) - $signed({1'b0, b});
    dc = $signed({1'b0, c}) - $signed({1'b0, d});
    return PW'(da) * PW'(dc);
  endfunction

  function automatic logic opp(logic na, logic pa, logic nb, logic pb);
    return (na && pb) || (pa && nb);
  endfunction

  // points: vertices 0..2, square corners 3..6
  logic [GW-1:0] px [7];
  logic [GW-1:0] py [7];
  logic signed [PW-1:0] a_next [NA];
  logic signed [PW-1:0] b_next [NA];
  logic signed [PW-1:0] oa_next [NO];
  logic signed [PW-1:0] ob_next [NO];
  logic          vin_next;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      px[i] = vx[i];
      py[i] = vy[i];
    end
    px[3] = x0;                 py[3] = y0;
    px[4] = x0 + GW'(size);     py[4] = y0;
    px[5] = x0 + GW'(size);     py[5] = y0 + GW'(size);
    px[6] = x0;                 py[6] = y0 + GW'(size);

    // sub-area products for each corner, then the triangle itself
    for (int c = 0; c < 4; c++) begin
      a_next[3*c]   = dm(px[1], px[3+c], py[2], py[3+c]);
      b_next[3*c]   = dm(px[2], px[3+c], py[1], py[3+c]);
      a_next[3*c+1] = dm(px[3+c], px[0], py[2], py[0]);
      b_next[3*c+1] = dm(px[2], px[0], py[3+c], py[0]);
      a_next[3*c+2] = dm(px[1], px[0], py[3+c], py[0]);
      b_next[3*c+2] = dm(px[3+c], px[0], py[1], py[0]);
    end
    a_next[12] = dm(px[1], px[0], py[2], py[0]);
    b_next[12] = dm(px[2], px[0], py[1], py[0]);

    // triangle edges against corners
    for (int i = 0; i < 3; i++) begin
      for (int c = 0; c < 4; c++) begin
        oa_next[4*i+c] = dm(px[i], px[3+c], py[(i == 2) ? 0 : i+1], py[3+c]);
        ob_next[4*i+c] = dm(px[(i == 2) ? 0 : i+1], px[3+c], py[i], py[3+c]);
      end
    end
    // square edges against vertices
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < 3; j++) begin
        oa_next[12+3*k+j] = dm(px[3+k], px[j], py[(k == 3) ? 3 : 4+k], py[j]);
        ob_next[12+3*k+j] = dm(px[(k == 3) ? 3 : 4+k], px[j], py[3+k], py[j]);
      end
    end

    // vertex within closed square
    vin_next = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (vx[i] >= x0 && vx[i] <= px[5] && vy[i] >= y0 && vy[i] <= py[5]) begin
        vin_next = 1'b1;
      end
    end
  end

  // stage 1: products
  logic signed [PW-1:0] a1 [NA];
  logic signed [PW-1:0] b1 [NA];
  logic signed [PW-1:0] oa1 [NO];
  logic signed [PW-1:0] ob1 [NO];
  logic          vin1;

  always_ff @(posedge clk) begin
    if (en) begin
      a1   <= a_next;
      b1   <= b_next;
      oa1  <= oa_next;
      ob1  <= ob_next;
      vin1 <= vin_next;
    end
  end

  // stage 2: absolute areas and orientation signs
  logic [AW-1:0] ar2 [NA];
  logic          neg2 [NO];
  logic          pos2 [NO];
  logic          vin2;

  always_ff @(posedge clk) begin
    logic signed [PW-1:0] d;
    logic signed [PW-1:0] m;
    if (en) begin
      for (int j = 0; j < NA; j++) begin
        d = a1[j] - b1[j];
        m = d[PW-1] ? -d : d;
        ar2[j] <= m[AW-1:0];
      end
      for (int j = 0; j < NO; j++) begin
        d = oa1[j] - ob1[j];
        neg2[j] <= d[PW-1];
        pos2[j] <= !d[PW-1] && (d != '0);
      end
      vin2 <= vin1;
    end
  end

  assign wa    = ar2[0];
  assign wb    = ar2[1];
  assign wc    = ar2[2];
  assign tarea = ar2[12];

  // stage 3: corner sums, crossings, final verdict
  always_ff @(posedge clk) begin
    logic          any;
    logic [AW+1:0] tot;
    int            c1;
    int            i1;
    if (en) begin
      any = vin2;
      for (int c = 0; c < 4; c++) begin
        tot = (AW+2)'(ar2[3*c]) + (AW+2)'(ar2[3*c+1]) + (AW+2)'(ar2[3*c+2]);
        if (tot == (AW+2)'(ar2[12])) any = 1'b1;
      end
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 4; k++) begin
          c1 = (k == 3) ? 0 : k + 1;
          i1 = (i == 2) ? 0 : i + 1;
          if (opp(neg2[4*i+k], pos2[4*i+k], neg2[4*i+c1], pos2[4*i+c1]) &&
              opp(neg2[12+3*k+i], pos2[12+3*k+i], neg2[12+3*k+i1], pos2[12+3*k+i1]))
            any = 1'b1;
        end
      end
      hit <= any;
    end
  end

endmodule

// ----- tb/tb_triangle_raster_supersample_interp_top.sv -----
// ----------------------------------------------------------------------------
// triangle rasteriser testbench
// drives pixels against a series of triangle setups, predicts the four sample
// results of every pixel and checks each transfer on the result channel
// ----------------------------------------------------------------------------
module tb_triangle_raster_supersample_interp_top
  import trsi_pkg::*;
();

  localparam int CB = 12;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int DRAIN_CYCLES = 24;

  typedef struct packed {
    logic                  pixel_covered;
    logic [1:0]            sample_index;
    logic                  sample_covered;
    logic [LEVEL_BITS-1:0] red_level;
    logic [LEVEL_BITS-1:0] green_level;
    logic [LEVEL_BITS-1:0] blue_level;
    logic                  last_sample;
  } sample_res_t;

  typedef struct packed {
    logic [CB-1:0] row;
    logic [CB-1:0] col;
  } pixel_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [23:0] cfg_data;

  trsi_in_if #(.COORD_BITS(CB)) pin ();
  trsi_out_if pout ();

  triangle_raster_supersample_interp_top #(.COORD_BITS(CB)) uut (
    .clk(clk), .rst(rst), .pix_in(pin), .res_out(pout),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow copy of the triangle setup
  logic [23:0] pos_reg [3];
  logic [20:0] col_reg [3];
  longint vx [3];
  longint vy [3];

  pixel_t      pixel_queue [$];
  sample_res_t sample_queue [$];
  int idle_pct;
  int stall_pct;
  bit failed;
  int cycles;

  // absolute doubled area
  function automatic longint area2(longint px, longint py, longint qx, longint qy,
                                   longint sx, longint sy);
    longint v;
    v = (qx - px) * (sy - py) - (sx - px) * (qy - py);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint orient(longint ax, longint ay, longint bx, longint by,
                                    longint px, longint py);
    return (ax - px) * (by - py) - (bx - px) * (ay - py);
  endfunction

  function automatic bit opp(longint a, longint b);
    return (a < 0 && b > 0) || (a > 0 && b < 0);
  endfunction

  // square against triangle: corner inside, vertex inside or strict crossing
  function automatic bit square_hits(longint x0, longint y0, longint sz);
    longint qx [4];
    longint qy [4];
    longint tarea, tot;
    int i, k, i1, k1;
    qx[0] = x0;      qy[0] = y0;
    qx[1] = x0 + sz; qy[1] = y0;
    qx[2] = x0 + sz; qy[2] = y0 + sz;
    qx[3] = x0;      qy[3] = y0 + sz;
    tarea = area2(vx[0], vy[0], vx[1], vy[1], vx[2], vy[2]);
    for (i = 0; i < 4; i++) begin
      tot = area2(qx[i], qy[i], vx[1], vy[1], vx[2], vy[2]) +
            area2(vx[0], vy[0], qx[i], qy[i], vx[2], vy[2]) +
            area2(vx[0], vy[0], vx[1], vy[1], qx[i], qy[i]);
      if (tot == tarea) return 1'b1;
    end
    for (i = 0; i < 3; i++)
      if (vx[i] >= x0 && vx[i] <= x0 + sz && vy[i] >= y0 && vy[i] <= y0 + sz)
        return 1'b1;
    for (i = 0; i < 3; i++) begin
      i1 = (i + 1) % 3;
      for (k = 0; k < 4; k++) begin
        k1 = (k + 1) % 4;
        if (opp(orient(vx[i], vy[i], vx[i1], vy[i1], qx[k], qy[k]),
                orient(vx[i], vy[i], vx[i1], vy[i1], qx[k1], qy[k1])) &&
            opp(orient(qx[k], qy[k], qx[k1], qy[k1], vx[i], vy[i]),
                orient(qx[k], qy[k], qx[k1], qy[k1], vx[i1], vy[i1])))
          return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // weighted colour, rounded half up, saturated
  function automatic logic [6:0] blend(longint wa, longint wb, longint wc, longint t,
                                       int sh);
    longint num, q;
    if (t == 0) return '0;
    num = wa * col_reg[0][sh +: 7] + wb * col_reg[1][sh +: 7] + wc * col_reg[2][sh +: 7];
    q = (2 * num + t) / (2 * t);
    return (q > LEVEL_MAX) ? 7'(LEVEL_MAX) : 7'(q);
  endfunction

  task automatic predict_samples(pixel_t p);
    longint x0, y0, t, sx, sy, wa, wb, wc;
    bit pix, cov;
    sample_res_t r;
    int s;
    x0 = 2 * longint'(p.col);
    y0 = 2 * longint'(p.row);
    t = area2(vx[0], vy[0], vx[1], vy[1], vx[2], vy[2]);
    pix = square_hits(x0, y0, 2);
    for (s = 0; s < 4; s++) begin
      sx = x0 + (s & 1);
      sy = y0 + (s >> 1);
      cov = pix && square_hits(sx, sy, 1);
      r = '0;
      r.pixel_covered = pix;
      r.sample_index = 2'(s);
      r.sample_covered = cov;
      r.last_sample = (s == 3);
      if (cov) begin
        wa = area2(sx, sy, vx[1], vy[1], vx[2], vy[2]);
        wb = area2(vx[0], vy[0], sx, sy, vx[2], vy[2]);
        wc = area2(vx[0], vy[0], vx[1], vy[1], sx, sy);
        r.red_level = blend(wa, wb, wc, t, 0);
        r.green_level = blend(wa, wb, wc, t, 7);
        r.blue_level = blend(wa, wb, wc, t, 14);
      end
      sample_queue.push_back(r);
    end
  endtask

  // clock
  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // pixel driver
  always @(posedge clk) begin
    if (rst) begin
      pin.valid <= 1'b0;
    end else begin
      if (pin.valid && pin.ready) predict_samples({pin.pixel_row, pin.pixel_col});
      if (!pin.valid || pin.ready) begin
        if (pixel_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
          pin.valid <= 1'b1;
          pin.pixel_row <= pixel_queue[0].row;
          pin.pixel_col <= pixel_queue[0].col;
          pixel_queue.pop_front();
        end else begin
          pin.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      pout.ready <= 1'b0;
    end else begin
      if (pout.valid && pout.ready) begin
        if (sample_queue.size() == 0) begin
          $display("%0t unexpected result %h", $time,
                   sample_res_t'{pout.pixel_covered, pout.sample_index,
                                 pout.sample_covered, pout.red_level, pout.green_level,
                                 pout.blue_level, pout.last_sample});
          failed = 1;
        end else begin
          if (pout.pixel_covered !== sample_queue[0].pixel_covered ||
              pout.sample_index !== sample_queue[0].sample_index ||
              pout.sample_covered !== sample_queue[0].sample_covered ||
              pout.red_level !== sample_queue[0].red_level ||
              pout.green_level !== sample_queue[0].green_level ||
              pout.blue_level !== sample_queue[0].blue_level ||
              pout.last_sample !== sample_queue[0].last_sample) begin
            $display("%0t expected cov %b idx %0d scov %b rgb %0d %0d %0d last %b",
                     $time, sample_queue[0].pixel_covered, sample_queue[0].sample_index,
                     sample_queue[0].sample_covered, sample_queue[0].red_level,
                     sample_queue[0].green_level, sample_queue[0].blue_level,
                     sample_queue[0].last_sample);
            $display("%0t actual   cov %b idx %0d scov %b rgb %0d %0d %0d last %b",
                     $time, pout.pixel_covered, pout.sample_index, pout.sample_covered,
                     pout.red_level, pout.green_level, pout.blue_level,
                     pout.last_sample);
            failed = 1;
          end
          sample_queue.pop_front();
        end
      end
      pout.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_setup(logic [23:0] a, logic [23:0] b, logic [23:0] c,
                             logic [20:0] ca, logic [20:0] cbc, logic [20:0] cc);
    int i;
    logic [23:0] vals [6];
    vals[0] = a; vals[1] = b; vals[2] = c;
    vals[3] = 24'(ca); vals[4] = 24'(cbc); vals[5] = 24'(cc);
    for (i = 0; i < 6; i++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= cfg_index_t'(i);
      cfg_data <= vals[i];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    pos_reg[0] = a; pos_reg[1] = b; pos_reg[2] = c;
    col_reg[0] = ca; col_reg[1] = cbc; col_reg[2] = cc;
    for (i = 0; i < 3; i++) begin
      vx[i] = 2 * longint'(pos_reg[i][11:0]);
      vy[i] = 2 * longint'(pos_reg[i][23:12]);
    end
  endtask

  // hold the sender until every sample of the phase has come back
  task automatic drain();
    do @(posedge clk);
    while (pixel_queue.size() > 0 || pin.valid || sample_queue.size() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [23:0] pos_of(int x, int y);
    return {12'(y), 12'(x)};
  endfunction

  function automatic logic [20:0] rand_colour();
    if ($urandom_range(9) == 0) return 21'($urandom);
    return {7'($urandom_range(100)), 7'($urandom_range(100)), 7'($urandom_range(100))};
  endfunction

  task automatic add_pixel(int row, int col);
    pixel_queue.push_back({12'(row), 12'(col)});
  endtask

  initial begin
    int ph, n, base, span;
    rst = 1;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    pin.valid = 0;
    pin.pixel_row = '0;
    pin.pixel_col = '0;
    pout.ready = 0;
    failed = 0;
    cycles = 0;
    idle_pct = 0;
    stall_pct = 0;
    for (int i = 0; i < 3; i++) begin
      pos_reg[i] = '0; col_reg[i] = '0; vx[i] = 0; vy[i] = 0;
    end
    repeat (9) @(posedge clk);
    rst <= 0;

    // degenerate triangle at the origin straight out of reset
    add_pixel(0, 0); add_pixel(0, 1); add_pixel(1, 0);
    add_pixel(4095, 4095); add_pixel(4095, 0); add_pixel(0, 4095);
    drain();

    // small triangle, primary colours, pixels on vertices, edges and inside
    write_setup(pos_of(2, 2), pos_of(20, 4), pos_of(6, 18),
                {7'd0, 7'd0, 7'd100}, {7'd0, 7'd100, 7'd0}, {7'd100, 7'd0, 7'd0});
    add_pixel(2, 2); add_pixel(4, 20); add_pixel(18, 6); add_pixel(8, 8);
    add_pixel(1, 1); add_pixel(3, 11); add_pixel(10, 13); add_pixel(0, 0);
    add_pixel(19, 19); add_pixel(4, 19); add_pixel(17, 6); add_pixel(11, 4);
    drain();

    // full-extent triangle, colour fields at their top value, saturation
    write_setup(pos_of(0, 0), pos_of(4095, 0), pos_of(0, 4095),
                21'h1FFFFF, 21'h1FFFFF, 21'h1FFFFF);
    idle_pct = 28; stall_pct = 28;
    add_pixel(4095, 4095); add_pixel(2047, 2047); add_pixel(2048, 2047);
    add_pixel(0, 4095); add_pixel(4095, 0);
    for (int i = 0; i < 30; i++) add_pixel($urandom_range(4095), $urandom_range(4095));
    drain();

    // collinear vertices: zero area, coverage only along the line
    write_setup(pos_of(1, 1), pos_of(5, 5), pos_of(9, 9),
                rand_colour(), rand_colour(), rand_colour());
    idle_pct = 0; stall_pct = 76;
    for (int i = 0; i < 12; i++) add_pixel(i, i);
    for (int i = 0; i < 12; i++) add_pixel($urandom_range(11), $urandom_range(11));
    drain();

    // random triangles around a random window, pixels mostly near it
    for (ph = 0; ph < 6; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 76; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 76; end
        default: begin idle_pct = 28; stall_pct = 28; end
      endcase
      span = (ph == 5) ? 4095 : $urandom_range(3, 40);
      base = (ph == 5) ? 0 : $urandom_range(4095 - span);
      write_setup(pos_of(base + $urandom_range(span), base + $urandom_range(span)),
                  pos_of(base + $urandom_range(span), base + $urandom_range(span)),
                  pos_of(base + $urandom_range(span), base + $urandom_range(span)),
                  rand_colour(), rand_colour(), rand_colour());
      n = 55;
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(9) == 0)
          add_pixel($urandom_range(4095), $urandom_range(4095));
        else
          add_pixel(base + $urandom_range(span), base + $urandom_range(span));
      end
      drain();
    end

    if (!failed) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
